// ----- rtl/dimr_pkg.sv -----
// Shared types and constants for the IR remote lamp dimmer.
// Used by the front, queue, back and top-level modules; depends on nothing.

package dimr_pkg;

    // Fixed remote addresses and their command bytes.
    localparam logic [15:0] ADDR_A  = 16'h7f00;
    localparam logic [7:0]  A_OFF   = 8'h53;
    localparam logic [7:0]  A_ON    = 8'h52;
    localparam logic [7:0]  A_PLUS  = 8'h51;
    localparam logic [7:0]  A_MINUS = 8'h50;
    localparam logic [15:0] ADDR_B  = 16'hff00;
    localparam logic [7:0]  B_OFF   = 8'h06;
    localparam logic [7:0]  B_ON    = 8'h07;
    localparam logic [7:0]  B_PLUS  = 8'h05;
    localparam logic [7:0]  B_MINUS = 8'h04;

    // Field widths.
    localparam int ADDR_W   = 16;
    localparam int CODE_W   = 8;
    localparam int DUTY_W   = 14;
    localparam int BRIGHT_W = 7;
    localparam int IN_W     = 24;
    localparam int USER_W   = 2;
    localparam int OUT_W    = 24;

    // Limits and step sizes.
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = 14'd10000;
    localparam logic [DUTY_W-1:0]   DUTY_STEP    = 14'd10;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_STEP  = 7'd10;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd50;

    // Queue between the front and back halves.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Work handed from the front to the back.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_OFF,
        ACT_ON,
        ACT_PLUS,
        ACT_MINUS,
        ACT_TICK
    } act_t;

endpackage

// ----- rtl/dimr_front.sv -----
// Front half of the dimmer: takes input transfers and classifies them.
// Depends on dimr_pkg for the remote codes and the action type.

module dimr_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dimr_pkg::IN_W-1:0]    s_tdata,
    input  logic [dimr_pkg::USER_W-1:0]  s_tuser,
    input  logic                         q_full,
    output logic                         push,
    output dimr_pkg::act_t               push_act
);

    logic [dimr_pkg::ADDR_W-1:0] address;
    logic [dimr_pkg::CODE_W-1:0] code;
    logic                        cmd;
    logic                        repeat_req;
    dimr_pkg::act_t              remote_act;

    assign address    = s_tdata[dimr_pkg::ADDR_W-1:0];
    assign code       = s_tdata[dimr_pkg::ADDR_W +: dimr_pkg::CODE_W];
    assign cmd        = s_tuser[0];
    assign repeat_req = s_tuser[1];

    always_comb
    begin
        remote_act = dimr_pkg::ACT_NONE;
        if (address == dimr_pkg::ADDR_A)
        begin
            if (code == dimr_pkg::A_OFF)        remote_act = dimr_pkg::ACT_OFF;
            else if (code == dimr_pkg::A_ON)    remote_act = dimr_pkg::ACT_ON;
            else if (code == dimr_pkg::A_PLUS)  remote_act = dimr_pkg::ACT_PLUS;
            else if (code == dimr_pkg::A_MINUS) remote_act = dimr_pkg::ACT_MINUS;
        end
        else if (address == dimr_pkg::ADDR_B)
        begin
            if (code == dimr_pkg::B_OFF)        remote_act = dimr_pkg::ACT_OFF;
            else if (code == dimr_pkg::B_ON)    remote_act = dimr_pkg::ACT_ON;
            else if (code == dimr_pkg::B_PLUS)  remote_act = dimr_pkg::ACT_PLUS;
            else if (code == dimr_pkg::B_MINUS) remote_act = dimr_pkg::ACT_MINUS;
        end
    end

    // Repeat frames still produce a result, but they change nothing.
    always_comb
    begin
        if (cmd)
            push_act = dimr_pkg::ACT_TICK;
        else if (repeat_req)
            push_act = dimr_pkg::ACT_NONE;
        else
            push_act = remote_act;
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

endmodule

// ----- rtl/dimr_queue.sv -----
// Short action queue that decouples the front and back halves of the dimmer.
// Depends on dimr_pkg for the action type and the queue depth.

module dimr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dimr_pkg::act_t push_act,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output dimr_pkg::act_t pop_act
);

    dimr_pkg::act_t                 mem [dimr_pkg::QDEPTH];
    logic [dimr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [dimr_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [dimr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [dimr_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [dimr_pkg::QCNT_W-1:0]    count_reg;
    logic [dimr_pkg::QCNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full      = (count_reg == dimr_pkg::QCNT_W'(dimr_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_act   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == dimr_pkg::QPTR_W'(dimr_pkg::QDEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == dimr_pkg::QPTR_W'(dimr_pkg::QDEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_act;
    end

endmodule

// ----- rtl/dimr_back.sv -----
// Back half of the dimmer: holds lamp state, runs the ramp, drives results.
// Depends on dimr_pkg for limits, step sizes and the action type.

module dimr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    input  dimr_pkg::act_t             q_act,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dimr_pkg::OUT_W-1:0] m_tdata
);

    logic                             lamp_reg;
    logic                             lamp_next;
    logic [dimr_pkg::BRIGHT_W-1:0]    bright_reg;
    logic [dimr_pkg::BRIGHT_W-1:0]    bright_next;
    logic [dimr_pkg::DUTY_W-1:0]      duty_reg;
    logic [dimr_pkg::DUTY_W-1:0]      duty_next;
    logic [dimr_pkg::DUTY_W-1:0]      target_reg;
    logic [dimr_pkg::DUTY_W-1:0]      target_next;
    logic [dimr_pkg::DUTY_W-1:0]      duty_up;
    logic                             changed;
    logic                             m_tvalid_reg;
    logic                             m_tvalid_next;
    logic [dimr_pkg::OUT_W-1:0]       m_tdata_reg;
    logic [dimr_pkg::OUT_W-1:0]       m_tdata_next;

    // Take an action whenever the output register is empty or being drained.
    assign q_pop = q_not_empty && (!m_tvalid_reg || m_tready);

    assign duty_up = duty_reg + dimr_pkg::DUTY_STEP;

    always_comb
    begin
        lamp_next   = lamp_reg;
        bright_next = bright_reg;
        duty_next   = duty_reg;
        changed     = 1'b0;
        case (q_act)
            dimr_pkg::ACT_OFF:
                lamp_next = 1'b0;
            dimr_pkg::ACT_ON:
                lamp_next = 1'b1;
            dimr_pkg::ACT_PLUS:
            begin
                if (lamp_reg)
                begin
                    if (bright_reg > dimr_pkg::BRIGHT_MAX - dimr_pkg::BRIGHT_STEP)
                        bright_next = dimr_pkg::BRIGHT_MAX;
                    else
                        bright_next = bright_reg + dimr_pkg::BRIGHT_STEP;
                end
            end
            dimr_pkg::ACT_MINUS:
            begin
                if (lamp_reg)
                begin
                    if (bright_reg < dimr_pkg::BRIGHT_STEP)
                        bright_next = '0;
                    else
                        bright_next = bright_reg - dimr_pkg::BRIGHT_STEP;
                end
            end
            dimr_pkg::ACT_TICK:
            begin
                if (duty_reg > target_reg)
                begin
                    changed = 1'b1;
                    if (duty_reg >= dimr_pkg::DUTY_STEP)
                        duty_next = duty_reg - dimr_pkg::DUTY_STEP;
                    else
                        duty_next = '0;
                end
                else if (duty_reg < target_reg)
                begin
                    changed = 1'b1;
                    if (duty_up > dimr_pkg::DUTY_MAX)
                        duty_next = dimr_pkg::DUTY_MAX;
                    else
                        duty_next = duty_up;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The ramp target is kept in a register so a tick sees no multiplier.
    always_comb
    begin
        if (lamp_next)
            target_next = dimr_pkg::DUTY_W'(bright_next) * dimr_pkg::DUTY_W'(bright_next);
        else
            target_next = '0;
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (q_pop)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, lamp_next, bright_next, changed, duty_next};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg     <= 1'b0;
            bright_reg   <= dimr_pkg::BRIGHT_RESET;
            duty_reg     <= '0;
            target_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                lamp_reg   <= lamp_next;
                bright_reg <= bright_next;
                duty_reg   <= duty_next;
                target_reg <= target_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/ir_remote_dimmer_with_ramp.sv -----
// Each input transfer reaches the output through the queue, then the output register.
// Throughput: one item per cycle while the output side keeps taking results.
// The rate is set by the output register, which takes a new action in the cycle it is drained.
// Reset (rst_n low, asynchronous) turns the lamp off, sets brightness to 50,
// the PWM level and ramp target to 0, and empties the queue and the output register.
// Top level of the IR remote lamp dimmer; uses dimr_pkg, dimr_front, dimr_queue, dimr_back.

module ir_remote_dimmer_with_ramp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dimr_pkg::IN_W-1:0]     s_tdata,   // address[15:0], code[23:16]
    input  logic [dimr_pkg::USER_W-1:0]   s_tuser,   // cmd[0], repeat_req[1]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dimr_pkg::OUT_W-1:0]    m_tdata    // pwm_level[13:0], pwm_changed[14],
                                                     // brightness[21:15], lamp_on[22], zero[23]
);

    // The front decodes every input transfer into one action: a ramp tick,
    // one of the four lamp commands, or nothing (repeat frames, unknown
    // remotes and unknown codes). Each action yields exactly one result, so nothing is dropped.
    logic           push;
    dimr_pkg::act_t push_act;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    dimr_pkg::act_t q_act;

    dimr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_act (push_act)
    );

    // The queue lets the input keep flowing while the output side stalls;
    // the front stops only once it is full.
    dimr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_act  (push_act),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_act   (q_act)
    );

    // The back holds the lamp state, carries out each action and writes the
    // result into the output register. The ramp target
    // (brightness squared when on) is registered alongside the state.
    dimr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_act       (q_act),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- rtl/dimr_checker.sv -----
// Port-level checks for the IR remote lamp dimmer, bound to the top level.
// Depends only on the top-level ports of ir_remote_dimmer_with_ramp.

module dimr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before transfer");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[13:0] <= 14'd10000)
        else $error("PWM level above full scale");

    a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[21:15] <= 7'd100) && !m_tdata[23])
        else $error("brightness out of range or pad bit set");

endmodule

bind ir_remote_dimmer_with_ramp dimr_checker u_dimr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
